/* src/qoi_pkg.sv */
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types and constants for the quaternion orientation integrator.
// ----------------------------------------------------------------------------
package qoi_pkg;

    localparam int unsigned CordicSteps = 16;
    localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
    localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
    localparam logic signed [15:0] OneQ14 = 16'sd16384;
    localparam logic [15:0] TimeStepReset = 16'd655;

    typedef logic signed [15:0] q16_t;

    typedef struct packed {
        q16_t rate_x;
        q16_t rate_y;
        q16_t rate_z;
    } rate_beat_t;

    typedef struct packed {
        q16_t quat_w;
        q16_t quat_x;
        q16_t quat_y;
        q16_t quat_z;
    } quat_beat_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQRT_START,
        OP_SQRT_STEP,
        OP_ANGLE,
        OP_CORDIC_STEP,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_MUL_STEP,
        OP_NORM_START,
        OP_QDIV_START,
        OP_STORE,
        OP_IDENT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_rate;
        logic zero_norm;
        logic unit_done;
    } dp_status_t;

    function automatic logic signed [33:0] atan_q30(input logic [3:0] i);
        logic signed [33:0] v;
        begin
            unique case (i)
                4'd0:  v = 34'sd843314857;
                4'd1:  v = 34'sd497837829;
                4'd2:  v = 34'sd263043837;
                4'd3:  v = 34'sd133525159;
                4'd4:  v = 34'sd67021687;
                4'd5:  v = 34'sd33543516;
                4'd6:  v = 34'sd16775851;
                4'd7:  v = 34'sd8388437;
                4'd8:  v = 34'sd4194283;
                4'd9:  v = 34'sd2097149;
                4'd10: v = 34'sd1048575;
                4'd11: v = 34'sd524287;
                4'd12: v = 34'sd262143;
                4'd13: v = 34'sd131071;
                4'd14: v = 34'sd65535;
                default: v = 34'sd32767;
            endcase
            return v;
        end
    endfunction

endpackage

/* src/qoi_if.sv */
// ----------------------------------------------------------------------------
// qoi_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface qoi_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/qoi_datapath.sv */
// ----------------------------------------------------------------------------
// qoi_datapath
// Registers and shared units: square root, CORDIC, divider, multiplier.
// ----------------------------------------------------------------------------
module qoi_datapath (
    input  logic                 clk,
    input  qoi_pkg::dp_cmd_t     cmd,
    input  qoi_pkg::rate_beat_t  rate,
    input  logic [15:0]          time_step,
    input  logic                 rst_n,
    output qoi_pkg::dp_status_t  status,
    output qoi_pkg::quat_beat_t  quat
);
    import qoi_pkg::*;

    q16_t r_reg [3];
    q16_t q_reg [4];
    logic [49:0] sum_reg;            // sum of squares, up to 50 bits
    logic [24:0] root_reg;
    logic [49:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] mag_reg;
    logic signed [35:0] cx_reg, cy_reg, cz_reg;
    logic        flip_reg;
    logic signed [33:0] s_reg, c_reg;
    logic signed [33:0] d_reg [4];
    logic signed [63:0] p_reg [4];
    logic signed [31:0] pn_reg [4];
    // shared restoring divider (magnitudes)
    logic [63:0] dnum_reg;
    logic [63:0] drem_reg;
    logic [24:0] dden_reg;
    logic        dneg_reg;
    logic        dvec_reg;

    // magnitude of divide numerator for vector part: |r*s| < 2^47
    logic signed [49:0] rs;
    logic signed [46:0] pq;
    logic [63:0] dtrial;
    logic [63:0] dshift;
    logic signed [35:0] sy, sx;
    logic signed [35:0] ang;
    logic [33:0] prod34;
    logic signed [49:0] mterm;
    logic [52:0] sq_trial;

    always_comb
    begin
        rs = 50'(r_reg[cmd.sel] * s_reg);
        pq = 47'(pn_reg[cmd.sel]) * 47'sd16384;
        dshift = {drem_reg[62:0], dnum_reg[63]};
        dtrial = dshift - {39'd0, dden_reg};
        sy = cy_reg >>> cnt_reg[3:0];
        sx = cx_reg >>> cnt_reg[3:0];
        prod34 = 34'(time_step * root_reg[15:0]) << 1;
        ang = $signed({2'b00, prod34});
        mterm = '0;
        sq_trial = {1'b0, rem_reg, sum_reg[49:48]} - 53'({root_reg, 2'b01});
    end

    // one Hamilton product term per cycle
    logic signed [63:0] hterm;
    logic [1:0] hi, hj;
    logic       hsub;
    always_comb
    begin
        hi = cnt_reg[3:2];
        hj = cnt_reg[1:0];
        hsub = 1'b0;
        unique case ({hi, hj})
            4'b0000: begin hj = 2'd0; hsub = 1'b0; end
            default: ;
        endcase
        hterm = 64'(q_reg[hj]) * 64'(d_reg[hi ^ hj]);
        // sign table of the Hamilton product, row = output, col = q index
        case ({hi, hj})
            4'b0001, 4'b0010, 4'b0011,
            4'b0111, 4'b1001, 4'b1110: hsub = 1'b1;
            default: hsub = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[0] <= OneQ14;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end
        else if (cmd.op == OP_STORE)
        begin
            q_reg[cmd.sel] <= (p_reg[cmd.sel] > 64'sd32767) ? 16'sh7fff :
                              (p_reg[cmd.sel] < -64'sd32768) ? 16'sh8000 :
                              16'(p_reg[cmd.sel]);
        end
        else if (cmd.op == OP_IDENT)
        begin
            q_reg[0] <= OneQ14;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                r_reg[0] <= rate.rate_x;
                r_reg[1] <= rate.rate_y;
                r_reg[2] <= rate.rate_z;
                sum_reg <= 50'(32'(rate.rate_x * rate.rate_x))
                         + 50'(32'(rate.rate_y * rate.rate_y))
                         + 50'(32'(rate.rate_z * rate.rate_z));
            end
            OP_SQRT_START:
            begin
                rem_reg <= '0;
                root_reg <= '0;
                cnt_reg <= 6'd25;
            end
            OP_NORM_START:
            begin
                sum_reg <= 50'(pn_reg[0] * pn_reg[0]) + 50'(pn_reg[1] * pn_reg[1])
                         + 50'(pn_reg[2] * pn_reg[2]) + 50'(pn_reg[3] * pn_reg[3]);
                rem_reg <= '0;
                root_reg <= '0;
                cnt_reg <= 6'd25;
            end
            OP_SQRT_STEP:
            begin
                // one result bit per cycle, two radicand bits shifted in
                if (!sq_trial[52])
                begin
                    rem_reg <= sq_trial[49:0];
                    root_reg <= {root_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[47:0], sum_reg[49:48]};
                    root_reg <= {root_reg[23:0], 1'b0};
                end
                sum_reg <= {sum_reg[47:0], 2'b00};
                cnt_reg <= cnt_reg - 6'd1;
            end
            OP_ANGLE:
            begin
                mag_reg <= root_reg[15:0];
                cnt_reg <= '0;
                flip_reg <= 1'b0;
                cx_reg <= 36'(CordicGainQ30);
                cy_reg <= '0;
                if (ang > PiQ30)
                begin
                    if (ang - TwoPiQ30 < -HalfPiQ30)
                    begin
                        cz_reg <= ang - TwoPiQ30 + PiQ30;
                        flip_reg <= 1'b1;
                    end
                    else
                        cz_reg <= ang - TwoPiQ30;
                end
                else if (ang > HalfPiQ30)
                begin
                    cz_reg <= ang - PiQ30;
                    flip_reg <= 1'b1;
                end
                else
                    cz_reg <= ang;
            end
            OP_CORDIC_STEP:
            begin
                if (!cz_reg[35])
                begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    cz_reg <= cz_reg - 36'(atan_q30(cnt_reg[3:0]));
                end
                else
                begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    cz_reg <= cz_reg + 36'(atan_q30(cnt_reg[3:0]));
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'd15)
                begin
                    if (cz_reg[35])
                    begin
                        s_reg <= flip_reg ? -34'(cy_reg - sx) : 34'(cy_reg - sx);
                        c_reg <= flip_reg ? -34'(cx_reg + sy) : 34'(cx_reg + sy);
                    end
                    else
                    begin
                        s_reg <= flip_reg ? -34'(cy_reg + sx) : 34'(cy_reg + sx);
                        c_reg <= flip_reg ? -34'(cx_reg - sy) : 34'(cx_reg - sy);
                    end
                end
            end
            OP_DIV_START:
            begin
                // vector part numerator r*s over magnitude
                if (cmd.sel == 2'd0)
                    d_reg[0] <= c_reg;
                dvec_reg <= 1'b1;
                dneg_reg <= rs[49];
                dnum_reg <= 64'(rs[49] ? -rs : rs);
                drem_reg <= '0;
                dden_reg <= {9'd0, mag_reg};
                cnt_reg <= '0;
            end
            OP_QDIV_START:
            begin
                dvec_reg <= 1'b0;
                dneg_reg <= pq[46];
                dnum_reg <= 64'(pq[46] ? -pq : pq);
                drem_reg <= '0;
                dden_reg <= root_reg;
                cnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                // one quotient bit per cycle
                if (!dtrial[63] || dshift >= {39'd0, dden_reg})
                begin
                    drem_reg <= dtrial;
                    dnum_reg <= {dnum_reg[62:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dshift;
                    dnum_reg <= {dnum_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            OP_MUL_STEP:
            begin
                if (hj == 2'd0)
                    p_reg[hi] <= hsub ? -hterm : hterm;
                else
                    p_reg[hi] <= hsub ? p_reg[hi] - hterm : p_reg[hi] + hterm;
                if (hj == 2'd3)
                    pn_reg[hi] <= 32'((hsub ? p_reg[hi] - hterm : p_reg[hi] + hterm) >>> 24);
                cnt_reg <= cnt_reg + 6'd1;
            end
            OP_STORE: ;
            default: ;
        endcase
        // quotient writeback after the last divide step
        if (cmd.op == OP_DIV_STEP && cnt_reg == 6'd63)
        begin
            if (dvec_reg)
                d_reg[cmd.sel + 2'd1] <= dneg_reg
                    ? -34'({dnum_reg[62:0], !dtrial[63]})
                    : 34'({dnum_reg[62:0], !dtrial[63]});
            else
                p_reg[cmd.sel] <= dneg_reg
                    ? -64'({dnum_reg[62:0], !dtrial[63]})
                    : 64'({dnum_reg[62:0], !dtrial[63]});
        end
    end

    assign status.zero_rate = (sum_reg == '0);
    assign status.zero_norm = (root_reg == '0);
    assign status.unit_done = (cmd.op == OP_SQRT_STEP) ? (cnt_reg == 6'd1)
                            : (cmd.op == OP_CORDIC_STEP) ? (cnt_reg[3:0] == 4'd15)
                            : (cmd.op == OP_DIV_STEP) ? (cnt_reg == 6'd63)
                            : (cmd.op == OP_MUL_STEP) ? (cnt_reg == 6'd15)
                            : (mterm != '0);

    assign quat.quat_w = q_reg[0];
    assign quat.quat_x = q_reg[1];
    assign quat.quat_y = q_reg[2];
    assign quat.quat_z = q_reg[3];

endmodule

/* src/qoi_ctrl.sv */
// ----------------------------------------------------------------------------
// qoi_ctrl
// Sequencer per sample: root, angle, CORDIC, divides, product, norm, rescale.
// ----------------------------------------------------------------------------
module qoi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  qoi_pkg::dp_status_t status,
    output qoi_pkg::dp_cmd_t    cmd
);
    import qoi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SQRT, S_ANGLE, S_CORDIC, S_VSTART, S_VDIV,
        S_MUL, S_NSTART, S_NSQRT, S_NCHECK, S_QSTART, S_QDIV, S_STORE, S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] sel_reg;

    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd.sel = sel_reg;
        unique case (state_reg)
            S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_OUT:    cmd.op = (in_valid && out_ready) ? OP_LOAD : OP_NONE;
            S_CHECK:  cmd.op = OP_SQRT_START;
            S_SQRT:   cmd.op = OP_SQRT_STEP;
            S_NSQRT:  cmd.op = OP_SQRT_STEP;
            S_ANGLE:  cmd.op = OP_ANGLE;
            S_CORDIC: cmd.op = OP_CORDIC_STEP;
            S_VSTART: cmd.op = OP_DIV_START;
            S_VDIV:   cmd.op = OP_DIV_STEP;
            S_QDIV:   cmd.op = OP_DIV_STEP;
            S_MUL:    cmd.op = OP_MUL_STEP;
            S_NSTART: cmd.op = OP_NORM_START;
            S_NCHECK: cmd.op = status.zero_norm ? OP_IDENT : OP_NONE;
            S_QSTART: cmd.op = OP_QDIV_START;
            S_STORE:  cmd.op = OP_STORE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE, S_OUT:
                    if (cmd.op == OP_LOAD)
                        state_reg <= S_CHECK;
                    else if (state_reg == S_OUT && out_ready)
                        state_reg <= S_IDLE;
                S_CHECK:  state_reg <= status.zero_rate ? S_OUT : S_SQRT;
                S_SQRT:   if (status.unit_done) state_reg <= S_ANGLE;
                S_ANGLE:  state_reg <= S_CORDIC;
                S_CORDIC:
                    if (status.unit_done)
                    begin
                        sel_reg <= '0;
                        state_reg <= S_VSTART;
                    end
                S_VSTART: state_reg <= S_VDIV;
                S_VDIV:
                    if (status.unit_done)
                    begin
                        sel_reg <= (sel_reg == 2'd2) ? 2'd0 : sel_reg + 2'd1;
                        state_reg <= (sel_reg == 2'd2) ? S_MUL : S_VSTART;
                    end
                S_MUL:    if (status.unit_done) state_reg <= S_NSTART;
                S_NSTART: state_reg <= S_NSQRT;
                S_NSQRT:  if (status.unit_done) state_reg <= S_NCHECK;
                S_NCHECK:
                begin
                    sel_reg <= '0;
                    state_reg <= status.zero_norm ? S_OUT : S_QSTART;
                end
                S_QSTART: state_reg <= S_QDIV;
                S_QDIV:   if (status.unit_done) state_reg <= S_STORE;
                S_STORE:
                begin
                    sel_reg <= sel_reg + 2'd1;
                    state_reg <= (sel_reg == 2'd3) ? S_OUT : S_QSTART;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/quaternion_orientation_integrator.sv */
// ----------------------------------------------------------------------------
// quaternion_orientation_integrator
// Result beat offered after the full sequence for a nonzero rate beat; sooner
// if the renormalized length is zero, after the check for a zero rate beat.
// One sample at a time: the next rate beat is taken in the cycle the result
// beat leaves. Bit-serial root, CORDIC and the 64-step divider (up to seven
// runs) set the time. Reset: orientation becomes the identity, time step 655;
// no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_orientation_integrator (
    input  logic        clk,
    input  logic        rst_n,
    qoi_if.sink         rate,
    qoi_if.source       quat,
    qoi_if.sink         cfg
);
    import qoi_pkg::*;

    logic [15:0] time_step_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;
    quat_beat_t  q;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= TimeStepReset;
        else if (cfg.valid)
            time_step_reg <= cfg.data;
    end

    qoi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rate.valid),
        .in_ready  (rate.ready),
        .out_valid (quat.valid),
        .out_ready (quat.ready),
        .status    (status),
        .cmd       (cmd)
    );

    qoi_datapath u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .rate      (rate.data),
        .time_step (time_step_reg),
        .rst_n     (rst_n),
        .status    (status),
        .quat      (q)
    );

    assign quat.data = q;

endmodule

/* tb/quaternion_orientation_integrator_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_orientation_integrator_tb
// Drives gyro rate samples through the integrator under several time steps,
// tracks the orientation in a bit-exact predictor and checks every quaternion.
// ----------------------------------------------------------------------------
module quaternion_orientation_integrator_tb;

    import qoi_pkg::*;

    localparam int NumRandom = 2000;
    localparam longint Pi2Q30 = 64'sd6746518852;
    localparam longint PiQ30L = 64'sd3373259426;
    localparam longint HalfPiL = 64'sd1686629713;

    class quat_scoreboard;
        quat_beat_t pending[$];
        q16_t       orient[4];
        logic [15:0] step;
        int         errors;
        int         checked;
        int         zero_rates;
        int         flips;

        function new();
            step = TimeStepReset;
            orient[0] = OneQ14;
            orient[1] = 0;
            orient[2] = 0;
            orient[3] = 0;
            errors = 0;
            checked = 0;
            zero_rates = 0;
            flips = 0;
        endfunction

        function automatic longint unsigned root64(longint unsigned v);
            longint unsigned r;
            longint unsigned bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > v)
                bt = bt >> 2;
            while (bt != 0)
            begin
                if (v >= r + bt)
                begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end
                else
                    r = r >> 1;
                bt = bt >> 2;
            end
            return r;
        endfunction

        function automatic q16_t clip16(longint v);
            if (v > 32767)
                return 16'sh7fff;
            if (v < -32768)
                return 16'sh8000;
            return q16_t'(v);
        endfunction

        // advance the orientation by one rate sample and queue the expected beat
        function void note_rate(rate_beat_t b);
            longint r[3];
            longint d[4];
            longint p[4];
            longint mag, half, x, y, z, nx;
            longint unsigned sum, norm2, norm;
            bit flip;
            quat_beat_t e;
            r[0] = longint'(b.rate_x);
            r[1] = longint'(b.rate_y);
            r[2] = longint'(b.rate_z);
            sum = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
            flip = 0;
            if (sum == 0)
                zero_rates++;
            else
            begin
                mag = longint'(root64(sum));
                half = (longint'(step) * mag) << 1;
                if (half > PiQ30L)
                    half = half - Pi2Q30;
                if (half > HalfPiL)
                begin
                    half = half - PiQ30L;
                    flip = 1;
                end
                else if (half < -HalfPiL)
                begin
                    half = half + PiQ30L;
                    flip = 1;
                end
                x = longint'(CordicGainQ30);
                y = 0;
                z = half;
                for (int i = 0; i < CordicSteps; i++)
                begin
                    if (z >= 0)
                    begin
                        nx = x - (y >>> i);
                        y = y + (x >>> i);
                        z = z - longint'(atan_q30(4'(i)));
                    end
                    else
                    begin
                        nx = x + (y >>> i);
                        y = y - (x >>> i);
                        z = z + longint'(atan_q30(4'(i)));
                    end
                    x = nx;
                end
                if (flip)
                begin
                    flips++;
                    x = -x;
                    y = -y;
                end
                d[0] = x;
                for (int i = 0; i < 3; i++)
                    d[i + 1] = (r[i] * y) / mag;
                p[0] = orient[0] * d[0] - orient[1] * d[1] - orient[2] * d[2]
                       - orient[3] * d[3];
                p[1] = orient[0] * d[1] + orient[1] * d[0] + orient[2] * d[3]
                       - orient[3] * d[2];
                p[2] = orient[0] * d[2] - orient[1] * d[3] + orient[2] * d[0]
                       + orient[3] * d[1];
                p[3] = orient[0] * d[3] + orient[1] * d[2] - orient[2] * d[1]
                       + orient[3] * d[0];
                norm2 = 0;
                for (int i = 0; i < 4; i++)
                begin
                    p[i] = p[i] >>> 24;
                    norm2 = norm2 + longint'(p[i] * p[i]);
                end
                norm = root64(norm2);
                if (norm == 0)
                begin
                    orient[0] = OneQ14;
                    orient[1] = 0;
                    orient[2] = 0;
                    orient[3] = 0;
                end
                else
                    for (int i = 0; i < 4; i++)
                        orient[i] = clip16((p[i] * 16384) / longint'(norm));
            end
            e.quat_w = orient[0];
            e.quat_x = orient[1];
            e.quat_y = orient[2];
            e.quat_z = orient[3];
            pending.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH %s: got %0d expected %0d (beat %0d)", what, got, want, checked);
            errors++;
        endtask

        task check_quat(quat_beat_t g);
            quat_beat_t e;
            if (pending.size() == 0)
            begin
                report("unexpected quat beat", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (g.quat_w !== e.quat_w) report("quat_w", g.quat_w, e.quat_w);
            if (g.quat_x !== e.quat_x) report("quat_x", g.quat_x, e.quat_x);
            if (g.quat_y !== e.quat_y) report("quat_y", g.quat_y, e.quat_y);
            if (g.quat_z !== e.quat_z) report("quat_z", g.quat_z, e.quat_z);
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    quat_scoreboard sb;
    int stall_mode;

    qoi_if #(.payload_t(rate_beat_t)) rate_ch ();
    qoi_if #(.payload_t(quat_beat_t)) quat_ch ();
    qoi_if #(.payload_t(logic [15:0])) cfg_ch ();

    quaternion_orientation_integrator i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rate (rate_ch.sink),
        .quat (quat_ch.source),
        .cfg  (cfg_ch.sink)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver stall pattern: mode 0 never stalls, others stall with varying density
    always @(posedge clk)
    begin
        if (stall_mode == 0)
            quat_ch.ready <= 1'b1;
        else if (stall_mode == 1)
            quat_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            quat_ch.ready <= ($urandom_range(0, 7) == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && quat_ch.valid && quat_ch.ready)
            sb.check_quat(quat_ch.data);
    end

    task send_rate(rate_beat_t b);
        rate_ch.valid <= 1'b1;
        rate_ch.data  <= b;
        do
            @(posedge clk);
        while (!rate_ch.ready);
        sb.note_rate(b);
    endtask

    task drain();
        rate_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task write_step(logic [15:0] v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.step = v;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic rate_beat_t mk_rate(int lim);
        rate_beat_t b;
        b.rate_x = q16_t'($urandom_range(0, 2 * lim) - lim);
        b.rate_y = q16_t'($urandom_range(0, 2 * lim) - lim);
        b.rate_z = q16_t'($urandom_range(0, 2 * lim) - lim);
        return b;
    endfunction

    function automatic rate_beat_t pick_rate();
        int k;
        k = $urandom_range(0, 99);
        if (k < 8)
            return '0;
        if (k < 25)
            return rate_beat_t'(48'({$urandom, $urandom}));
        if (k < 35)
        begin
            pick_rate = '0;
            pick_rate.rate_y = q16_t'($urandom);
            return pick_rate;
        end
        return mk_rate((k < 60) ? 64 : 4096);
    endfunction

    task random_burst(int count);
        int left;
        left = count;
        while (left > 0)
        begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                send_rate(pick_rate());
                left--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                rate_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 500)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        sb = new();
        stall_mode = 0;
        rst_n = 1'b0;
        rate_ch.valid = 1'b0;
        rate_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        quat_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero rate, extremes, single axes, large angles that fold
        send_rate('0);
        send_rate('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_rate('{16'sh8000, 16'sh8000, 16'sh8000});
        send_rate('{16'sh0001, 16'sh0000, 16'sh0000});
        send_rate('{16'sh0000, 16'shffff, 16'sh0000});
        send_rate('{16'sh0000, 16'sh0000, 16'sh1000});
        send_rate('0);
        send_rate('{16'sh8000, 16'sh7fff, 16'sh0001});
        write_step(16'hffff);
        send_rate('{16'sh7fff, 16'sh0000, 16'sh0000});
        send_rate('{16'sh8000, 16'sh8000, 16'sh8000});
        send_rate('{16'sh2000, 16'she000, 16'sh1000});
        send_rate('{16'sh0001, 16'sh0001, 16'sh0001});
        write_step(16'h0000);
        send_rate('{16'sh7fff, 16'sh1234, 16'sh8000});
        send_rate('{16'sh0003, 16'sh0000, 16'shfffd});
        send_rate('0);
        write_step(16'h8000);
        for (int i = 0; i < 6; i++)
            send_rate(mk_rate(32767));

        // random phases under several time steps and receiver stall densities
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_step(TimeStepReset);
                1: write_step(16'hffff);
                2: write_step(16'h0000);
                3: write_step(16'h0001);
                default: write_step(16'($urandom));
            endcase
            stall_mode = ph % 3;
            random_burst(NumRandom / 6);
        end

        drain();
        $display("covered %0d quaternion beats, %0d zero-rate samples, %0d folded angles",
                 sb.checked, sb.zero_rates, sb.flips);
        $display("time steps swept: reset value, zero, one, full scale and random");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("timeout: %0d beats still expected", sb.pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
src/qoi_pkg.sv
src/qoi_if.sv
src/qoi_datapath.sv
src/qoi_ctrl.sv
src/quaternion_orientation_integrator.sv
tb/quaternion_orientation_integrator_tb.sv
